FILE: hdl/dpg_pkg.sv
// Shared types and constants for the dot product random graph block.
package dpg_pkg;

   // Item kinds carried on req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_DRAW = 1'b1;

   // Register indexes on the csr port
   localparam logic [1:0] REG_NUM_VERTICES = 2'd0;
   localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
   localparam logic [1:0] REG_DIRECTED     = 2'd2;

   // Register reset values
   localparam logic [10:0] NUM_VERTICES_RST = 11'd2;
   localparam logic [4:0]  NUM_DIMS_RST     = 5'd1;

   // One in Q4.28
   localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // Control of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   // Control of the pair walker
   typedef struct packed {
      logic restart;
      logic step;
   } walk_ctl_type;

   // Decision for the current pair
   typedef struct packed {
      logic edge_present;
      logic negative_seen;
      logic above_one_seen;
      logic last_pair;
   } walk_res_type;

endpackage

FILE: hdl/dot_product_random_graph.sv
// Top level of the dot product random graph pair walker.
//
// req channel: tuser = 0 loads one Q2.14 coordinate of one vertex into the
// vector store and restarts the pair walk; tuser = 1 draws the next pair.
// Loads complete in the cycle they transfer and return nothing. A draw
// returns one rsp transfer with the pair, the edge decision, the two sticky
// flags and tlast on the final pair of the walk.
// csr port: registers 0 num_vertices, 1 num_dims, 2 directed_mode; each
// write to one of these restarts the walk. Write only while idle.
// A draw is worked by the single multiply-accumulate unit, which walks its
// coordinates (num_dims counted after clamping to MAX_DIMS) one per cycle
// from two copies of the store. req_tready stays low while a draw is in
// progress; it rises as the result is loaded, so no new request is taken
// until the previous draw's result has gone into the output register.
// Reset clears registers to their defaults, the walk to pair (0, 1) and the
// flags; the vector store keeps no reset and must be loaded before use.
// A stalled receiver holds the result in the output register; loads and
// one more draw may be taken meanwhile, and that draw then waits for the slot.
module dot_product_random_graph #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_DIMS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   // csr write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   // req: tdata = vertex_index[9:0], coord_index[13:10],
   //      coord_value[29:14], uniform_sample[45:30], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,   // func
   // rsp: tdata = from_vertex[9:0], to_vertex[19:10], edge_present[20],
   //      negative_seen[21], above_one_seen[22], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast    // last_pair
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int NW    = VW + 1;
   localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KW    = $clog2(MAX_DIMS + 1);
   localparam int DEPTH = MAX_VERTICES * (2 ** DW);
   localparam int AW    = VW + DW;
   localparam int ACC_W = 33 + DW;

   dpg_pkg::state_type    state_ff, state_in;
   dpg_pkg::mac_ctl_type  mac_ctl;
   dpg_pkg::walk_ctl_type walk_ctl;
   dpg_pkg::walk_res_type walk_res;

   logic [10:0]   num_vertices_ff;
   logic [4:0]    num_dims_ff;
   logic          directed_ff;
   logic          csr_hit;

   logic [KW-1:0] k_ff, k_in;
   logic          issue_v_ff, issue;
   logic [15:0]   uniform_ff;

   logic          req_xfer, load_xfer, draw_xfer, load_ok;
   logic [31:0]   load_v_wide, load_c_wide, nv_wide, nv_eff_wide, nd_wide, nd_eff_wide;
   logic [NW-1:0] n_eff;
   logic [KW-1:0] d_eff;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [15:0]   x_data, y_data;
   logic          mac_busy;
   logic signed [31:0] product;
   logic [VW-1:0] walk_first, walk_second;
   logic [VW+9:0] from_ext, to_ext;
   logic          rsp_load;

   logic          rsp_valid_ff;
   logic [9:0]    rsp_from_ff, rsp_to_ff;
   logic          rsp_edge_ff, rsp_neg_ff, rsp_big_ff, rsp_last_ff;

   // Input handshake and load decode
   assign req_tready  = (state_ff == dpg_pkg::ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign load_xfer   = req_xfer && (req_tuser == dpg_pkg::FUNC_LOAD);
   assign draw_xfer   = req_xfer && (req_tuser == dpg_pkg::FUNC_DRAW);
   assign load_v_wide = {22'b0, req_tdata[9:0]};
   assign load_c_wide = {28'b0, req_tdata[13:10]};
   assign load_ok     = (load_v_wide < 32'(MAX_VERTICES)) && (load_c_wide < 32'(MAX_DIMS));
   assign wr_addr     = {load_v_wide[VW-1:0], load_c_wide[DW-1:0]};

   // Configuration registers
   assign csr_hit = csr_we && ((csr_index == dpg_pkg::REG_NUM_VERTICES) ||
                               (csr_index == dpg_pkg::REG_NUM_DIMS) ||
                               (csr_index == dpg_pkg::REG_DIRECTED));

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= dpg_pkg::NUM_VERTICES_RST;
         num_dims_ff     <= dpg_pkg::NUM_DIMS_RST;
         directed_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            dpg_pkg::REG_NUM_VERTICES: num_vertices_ff <= csr_wdata;
            dpg_pkg::REG_NUM_DIMS:     num_dims_ff     <= csr_wdata[4:0];
            dpg_pkg::REG_DIRECTED:     directed_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp vertex and dimension counts
   always_comb begin
      nv_wide = {21'b0, num_vertices_ff};
      nd_wide = {27'b0, num_dims_ff};
      if (nv_wide < 32'd2) begin
         nv_eff_wide = 32'd2;
      end else if (nv_wide > 32'(MAX_VERTICES)) begin
         nv_eff_wide = 32'(MAX_VERTICES);
      end else begin
         nv_eff_wide = nv_wide;
      end
      nd_eff_wide = (nd_wide > 32'(MAX_DIMS)) ? 32'(MAX_DIMS) : nd_wide;
   end

   assign n_eff = nv_eff_wide[NW-1:0];
   assign d_eff = nd_eff_wide[KW-1:0];

   // Sequencer
   assign issue    = (state_ff == dpg_pkg::ST_RUN) && (k_ff < d_eff);
   assign rsp_load = (state_ff == dpg_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         dpg_pkg::ST_IDLE: begin
            k_in = '0;
            if (draw_xfer) begin
               state_in = dpg_pkg::ST_RUN;
            end
         end
         dpg_pkg::ST_RUN: begin
            if (issue) begin
               k_in = k_ff + KW'(1);
            end else begin
               state_in = dpg_pkg::ST_DRAIN;
            end
         end
         dpg_pkg::ST_DRAIN: begin
            if (!issue_v_ff && !mac_busy) begin
               state_in = dpg_pkg::ST_DONE;
            end
         end
         dpg_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = dpg_pkg::ST_IDLE;
            end
         end
         default: state_in = dpg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dpg_pkg::ST_IDLE;
         k_ff       <= '0;
         issue_v_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         k_ff       <= k_in;
         issue_v_ff <= issue;
      end
      if (draw_xfer) begin
         uniform_ff <= req_tdata[45:30];
      end
   end

   // Two copies of the vector store, one per vertex of the pair
   assign rd_addr_a = {walk_first, k_ff[DW-1:0]};
   assign rd_addr_b = {walk_second, k_ff[DW-1:0]};

   dpg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (load_xfer && load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[29:14]),
      .rd_addr (rd_addr_a),
      .rd_data (x_data)
   );

   dpg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (load_xfer && load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_tdata[29:14]),
      .rd_addr (rd_addr_b),
      .rd_data (y_data)
   );

   // Multiply-accumulate over the coordinates
   assign mac_ctl.clear = draw_xfer;
   assign mac_ctl.valid = issue_v_ff;

   dpg_mac #(.ACC_W(ACC_W)) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .x     ($signed(x_data)),
      .y     ($signed(y_data)),
      .busy  (mac_busy),
      .sum   (product)
   );

   // Pair walker
   assign walk_ctl.restart = load_xfer || csr_hit;
   assign walk_ctl.step    = rsp_load;

   dpg_walk #(.VW(VW), .NW(NW)) u_walk (
      .clock    (clock),
      .reset    (reset),
      .ctl      (walk_ctl),
      .n_eff    (n_eff),
      .directed (directed_ff),
      .product  (product),
      .uniform  (uniform_ff),
      .first    (walk_first),
      .second   (walk_second),
      .res      (walk_res)
   );

   // Output register
   assign from_ext = {10'b0, walk_first};
   assign to_ext   = {10'b0, walk_second};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_from_ff <= from_ext[9:0];
         rsp_to_ff   <= to_ext[9:0];
         rsp_edge_ff <= walk_res.edge_present;
         rsp_neg_ff  <= walk_res.negative_seen;
         rsp_big_ff  <= walk_res.above_one_seen;
         rsp_last_ff <= walk_res.last_pair;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_big_ff, rsp_neg_ff, rsp_edge_ff, rsp_to_ff, rsp_from_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/dpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dpg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dpg_mac.sv
// Multiply-accumulate unit with saturation to signed Q4.28.
module dpg_mac #(
   parameter int ACC_W = 38
) (
   input  logic                clock,
   input  logic                reset,
   input  dpg_pkg::mac_ctl_type ctl,
   input  logic signed [15:0]  x,
   input  logic signed [15:0]  y,
   output logic                busy,
   output logic signed [31:0]  sum
);

   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

   logic signed [31:0]      prod_ff, prod_in;
   logic                    prod_v_ff, prod_v_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Multiply stage, then accumulate stage
   always_comb begin
      prod_in   = x * y;
      prod_v_in = ctl.valid;
      acc_in    = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         prod_v_ff <= prod_v_in;
         acc_ff    <= acc_in;
      end
      prod_ff <= prod_in;
   end

   // Clamp the total to 32 bits
   always_comb begin
      if (acc_ff > SAT_HI) begin
         sum = 32'sh7FFF_FFFF;
      end else if (acc_ff < SAT_LO) begin
         sum = 32'sh8000_0000;
      end else begin
         sum = acc_ff[31:0];
      end
   end

   assign busy = prod_v_ff;

endmodule

FILE: hdl/dpg_walk.sv
// Pair walker: current vertex pair, sticky flags and edge decision.
module dpg_walk #(
   parameter int VW = 10,
   parameter int NW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dpg_pkg::walk_ctl_type ctl,
   input  logic [NW-1:0]        n_eff,
   input  logic                 directed,
   input  logic signed [31:0]   product,
   input  logic [15:0]          uniform,
   output logic [VW-1:0]        first,
   output logic [VW-1:0]        second,
   output dpg_pkg::walk_res_type res
);

   logic [VW-1:0] first_ff, first_in;
   logic [VW-1:0] second_ff, second_in;
   logic          neg_ff, neg_in;
   logic          big_ff, big_in;
   logic [NW-1:0] i_x, j_x, nj, nj2;
   logic [NW-1:0] n_m1, n_m2;
   logic          last;
   logic          edge_bit;
   logic signed [31:0] u_q28;

   // Edge decision and flag update
   always_comb begin
      u_q28    = $signed({4'b0, uniform, 12'b0});
      neg_in   = neg_ff;
      big_in   = big_ff;
      if (product < 0 && !neg_ff) begin
         edge_bit = 1'b0;
         neg_in   = 1'b1;
      end else if (product > dpg_pkg::ONE_Q28 && !big_ff) begin
         edge_bit = 1'b1;
         big_in   = 1'b1;
      end else begin
         edge_bit = u_q28 < product;
      end
   end

   // End of walk and next pair
   always_comb begin
      i_x  = NW'(first_ff);
      j_x  = NW'(second_ff);
      n_m1 = n_eff - NW'(1);
      n_m2 = n_eff - NW'(2);
      nj   = j_x + NW'(1);
      nj2  = (nj == i_x) ? nj + NW'(1) : nj;
      if (directed) begin
         last = (i_x == n_m1) && (j_x == n_m2);
      end else begin
         last = (i_x == n_m2) && (j_x == n_m1);
      end
      first_in  = first_ff;
      second_in = second_ff;
      if (directed) begin
         if (nj2 >= n_eff) begin
            first_in  = first_ff + VW'(1);
            second_in = '0;
         end else begin
            second_in = nj2[VW-1:0];
         end
      end else begin
         if (nj < n_eff) begin
            second_in = nj[VW-1:0];
         end else begin
            first_in  = first_ff + VW'(1);
            second_in = first_ff + VW'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.restart || (ctl.step && last)) begin
         first_ff  <= '0;
         second_ff <= VW'(1);
         neg_ff    <= 1'b0;
         big_ff    <= 1'b0;
      end else if (ctl.step) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         neg_ff    <= neg_in;
         big_ff    <= big_in;
      end
   end

   assign first              = first_ff;
   assign second             = second_ff;
   assign res.edge_present   = edge_bit;
   assign res.negative_seen  = neg_in;
   assign res.above_one_seen = big_in;
   assign res.last_pair      = last;

endmodule

FILE: hdl/dpg_check.sv
// Port-level checks for the dot product random graph block, with bind.
module dpg_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Held result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // No result comes out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // A draw transfer is followed at once by req_tready low
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input taken during a draw");

   // A pair never joins a vertex to itself
   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:0] != rsp_tdata[19:10])
      else $error("pair with equal vertices");

endmodule

bind dot_product_random_graph dpg_check u_dpg_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
